// File: rtl/bblru_pkg.sv
`default_nettype none
package bblru_pkg;

    localparam int KEY_W    = 64;
    localparam int HEIGHT_W = 12;
    localparam int SIZE_W   = 32;
    localparam int STAMP_W  = 48;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int CMD_W    = 2;

    localparam logic [SIZE_W-1:0] BUDGET_RESET = 32'd67108864;

    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ABANDON = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STORED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DROPPED     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_PENDING = 3'd6;
    localparam logic [STATUS_W-1:0] ST_EVICTED     = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_REBUILD,
        S_SCAN,
        S_EVICT
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ALLOC,
        OP_FINISH,
        OP_TOUCH,
        OP_FREE
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [KEY_W-1:0]      key;
        logic [HEIGHT_W-1:0]   height;
        logic [SIZE_W-1:0]     size;
        logic [STAMP_W-1:0]    stamp;
    } cell_wr_t;

    typedef struct packed {
        logic valid;
        logic pending;
        logic match;
    } cell_stat_t;

endpackage
`default_nettype wire

// File: rtl/bblru_cell.sv
`default_nettype none
module bblru_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bblru_pkg::cell_wr_t           wr,
    input  wire logic [bblru_pkg::KEY_W-1:0]    lookup_key,
    input  wire logic [bblru_pkg::HEIGHT_W-1:0] lookup_height,
    output bblru_pkg::cell_stat_t              stat,
    output logic [bblru_pkg::KEY_W-1:0]         key,
    output logic [bblru_pkg::HEIGHT_W-1:0]      height,
    output logic [bblru_pkg::SIZE_W-1:0]        size,
    output logic [bblru_pkg::STAMP_W-1:0]       stamp
);

    logic                           valid_reg;
    logic                           pending_reg;
    logic [bblru_pkg::KEY_W-1:0]    key_reg;
    logic [bblru_pkg::HEIGHT_W-1:0] height_reg;
    logic [bblru_pkg::SIZE_W-1:0]   size_reg;
    logic [bblru_pkg::STAMP_W-1:0]  stamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            case (wr.op)
                bblru_pkg::OP_ALLOC: begin
                    valid_reg   <= 1'b1;
                    pending_reg <= 1'b1;
                end
                bblru_pkg::OP_FINISH: pending_reg <= 1'b0;
                bblru_pkg::OP_FREE: begin
                    valid_reg   <= 1'b0;
                    pending_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (wr.op)
            bblru_pkg::OP_ALLOC: begin
                key_reg    <= wr.key;
                height_reg <= wr.height;
            end
            bblru_pkg::OP_FINISH: begin
                size_reg  <= wr.size;
                stamp_reg <= wr.stamp;
            end
            bblru_pkg::OP_TOUCH: stamp_reg <= wr.stamp;
            default: ;
        endcase
    end

    assign stat.valid   = valid_reg;
    assign stat.pending = pending_reg;
    assign stat.match   = valid_reg && (key_reg == lookup_key) && (height_reg == lookup_height);
    assign key    = key_reg;
    assign height = height_reg;
    assign size   = size_reg;
    assign stamp  = stamp_reg;

endmodule
`default_nettype wire

// File: rtl/byte_budget_lru_cache_top.sv
`default_nettype none
// An input is registered on transfer; its result is registered from the LOOKUP state once
// the output is free, and a forced rebuild registers its second result from the REBUILD
// state once the first is taken. After a finish, each eviction scans every cell for the
// oldest stamp, then frees it. A new input is taken once the last result of the current
// one is registered. Synchronous active-low reset clears all entries, the use counter and
// the retained byte count; budget resets to 64 MiB.
module byte_budget_lru_cache_top #(
    parameter int ENTRIES = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bblru_pkg::SIZE_W-1:0]      cfg_byte_budget,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [bblru_pkg::CMD_W-1:0]       s_cmd,
    input  wire logic [bblru_pkg::KEY_W-1:0]       s_key_digest,
    input  wire logic [bblru_pkg::HEIGHT_W-1:0]    s_pixel_height,
    input  wire logic                              s_force_rebuild,
    input  wire logic [bblru_pkg::SIZE_W-1:0]      s_item_bytes,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [bblru_pkg::STATUS_W-1:0]         m_status,
    output logic [bblru_pkg::SLOT_W-1:0]           m_slot,
    output logic [bblru_pkg::KEY_W-1:0]            m_out_key_digest,
    output logic [bblru_pkg::HEIGHT_W-1:0]         m_out_pixel_height,
    output logic                                   m_last
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int RW    = bblru_pkg::SIZE_W + IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    bblru_pkg::state_t state_reg, state_next;

    logic [bblru_pkg::CMD_W-1:0]    cmd_reg;
    logic [bblru_pkg::KEY_W-1:0]    key_reg;
    logic [bblru_pkg::HEIGHT_W-1:0] height_reg;
    logic                           force_reg;
    logic [bblru_pkg::SIZE_W-1:0]   bytes_reg;

    logic [bblru_pkg::SIZE_W-1:0]   budget_reg;
    logic [bblru_pkg::STAMP_W-1:0]  counter_reg, counter_next;
    logic [RW-1:0]                  retained_reg, retained_next;
    logic [IDX_W-1:0]               slot_reg, slot_next;
    logic [IDX_W-1:0]               scan_idx_reg, scan_idx_next;
    logic                           best_found_reg, best_found_next;
    logic [IDX_W-1:0]               best_idx_reg, best_idx_next;
    logic [bblru_pkg::STAMP_W-1:0]  best_stamp_reg, best_stamp_next;

    logic                           m_valid_reg, m_valid_next;
    logic [bblru_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [bblru_pkg::SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic [bblru_pkg::KEY_W-1:0]    m_key_reg, m_key_next;
    logic [bblru_pkg::HEIGHT_W-1:0] m_height_reg, m_height_next;
    logic                           m_last_reg, m_last_next;

    bblru_pkg::cell_stat_t          cell_stat   [ENTRIES];
    logic [bblru_pkg::KEY_W-1:0]    cell_key    [ENTRIES];
    logic [bblru_pkg::HEIGHT_W-1:0] cell_height [ENTRIES];
    logic [bblru_pkg::SIZE_W-1:0]   cell_size   [ENTRIES];
    logic [bblru_pkg::STAMP_W-1:0]  cell_stamp  [ENTRIES];
    bblru_pkg::cell_wr_t            cell_wr     [ENTRIES];

    bblru_pkg::cell_op_t            op;
    logic [IDX_W-1:0]               op_idx;
    logic [bblru_pkg::SIZE_W-1:0]   op_size;

    logic                           hit_found, free_found;
    logic [IDX_W-1:0]               hit_idx, free_idx;
    logic                           hit_pending;
    logic                           out_free;
    logic [bblru_pkg::STAMP_W-1:0]  stamp_inc;
    logic [RW-1:0]                  retained_fin, retained_evict;
    logic                           fin_over, evict_over;
    logic                           scan_take;

    function automatic logic [bblru_pkg::SLOT_W-1:0] SLOT_CAST(input logic [IDX_W-1:0] idx);
        return bblru_pkg::SLOT_W'(idx);
    endfunction

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            bblru_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .wr            (cell_wr[g]),
                .lookup_key    (key_reg),
                .lookup_height (height_reg),
                .stat          (cell_stat[g]),
                .key           (cell_key[g]),
                .height        (cell_height[g]),
                .size          (cell_size[g]),
                .stamp         (cell_stamp[g])
            );
        end
    endgenerate

    // Lowest matching and lowest free slot.
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (cell_stat[i].match) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!cell_stat[i].valid) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign hit_pending    = cell_stat[hit_idx].pending;
    assign out_free       = !m_valid_reg || m_ready;
    assign stamp_inc      = counter_reg + 1'b1;
    assign retained_fin   = retained_reg + RW'(bytes_reg);
    assign retained_evict = retained_reg - RW'(cell_size[best_idx_reg]);
    assign fin_over       = retained_fin > RW'(budget_reg);
    assign evict_over     = retained_evict > RW'(budget_reg);
    assign scan_take      = cell_stat[scan_idx_reg].valid && !cell_stat[scan_idx_reg].pending
                            && (!best_found_reg || cell_stamp[scan_idx_reg] < best_stamp_reg);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            cell_wr[i].op     = (op_idx == IDX_W'(i)) ? op : bblru_pkg::OP_NOP;
            cell_wr[i].key    = key_reg;
            cell_wr[i].height = height_reg;
            cell_wr[i].size   = op_size;
            cell_wr[i].stamp  = stamp_inc;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bblru_pkg::S_IDLE: begin
                if (s_valid) state_next = bblru_pkg::S_LOOKUP;
            end
            bblru_pkg::S_LOOKUP: begin
                if (out_free) begin
                    state_next = bblru_pkg::S_IDLE;
                    if (cmd_reg == bblru_pkg::CMD_LOOKUP && hit_found && !hit_pending
                        && force_reg)
                        state_next = bblru_pkg::S_REBUILD;
                    if (cmd_reg == bblru_pkg::CMD_FINISH && hit_found && hit_pending
                        && fin_over)
                        state_next = bblru_pkg::S_SCAN;
                end
            end
            bblru_pkg::S_REBUILD: begin
                if (out_free) state_next = bblru_pkg::S_IDLE;
            end
            bblru_pkg::S_SCAN: begin
                if (scan_idx_reg == LAST_IDX) state_next = bblru_pkg::S_EVICT;
            end
            bblru_pkg::S_EVICT: begin
                if (out_free) state_next = evict_over ? bblru_pkg::S_SCAN : bblru_pkg::S_IDLE;
            end
            default: state_next = bblru_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        op              = bblru_pkg::OP_NOP;
        op_idx          = hit_idx;
        op_size         = bytes_reg;
        counter_next    = counter_reg;
        retained_next   = retained_reg;
        slot_next       = slot_reg;
        scan_idx_next   = scan_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_key_next      = m_key_reg;
        m_height_next   = m_height_reg;
        m_last_next     = m_last_reg;
        case (state_reg)
            bblru_pkg::S_LOOKUP: begin
                if (out_free && cmd_reg != bblru_pkg::CMD_UNUSED) begin
                    m_valid_next  = 1'b1;
                    m_key_next    = key_reg;
                    m_height_next = height_reg;
                    m_last_next   = 1'b1;
                    m_slot_next   = SLOT_CAST(hit_idx);
                    if (cmd_reg == bblru_pkg::CMD_LOOKUP) begin
                        if (hit_found && hit_pending) begin
                            m_status_next = bblru_pkg::ST_BUSY;
                        end else if (hit_found && !force_reg) begin
                            op            = bblru_pkg::OP_TOUCH;
                            counter_next  = stamp_inc;
                            m_status_next = bblru_pkg::ST_HIT;
                        end else if (hit_found) begin
                            // drop now, reserve the same slot in the REBUILD state
                            retained_next = retained_reg - RW'(cell_size[hit_idx]);
                            slot_next     = hit_idx;
                            m_status_next = bblru_pkg::ST_DROPPED;
                            m_last_next   = 1'b0;
                        end else if (free_found) begin
                            op            = bblru_pkg::OP_ALLOC;
                            op_idx        = free_idx;
                            m_status_next = bblru_pkg::ST_MISS;
                            m_slot_next   = SLOT_CAST(free_idx);
                        end else begin
                            m_status_next = bblru_pkg::ST_FULL;
                            m_slot_next   = '0;
                        end
                    end else if (!hit_found || !hit_pending) begin
                        m_status_next = bblru_pkg::ST_NOT_PENDING;
                        if (!hit_found) m_slot_next = '0;
                    end else if (cmd_reg == bblru_pkg::CMD_ABANDON) begin
                        op            = bblru_pkg::OP_FREE;
                        m_status_next = bblru_pkg::ST_DROPPED;
                    end else begin
                        op              = bblru_pkg::OP_FINISH;
                        counter_next    = stamp_inc;
                        retained_next   = retained_fin;
                        m_status_next   = bblru_pkg::ST_STORED;
                        m_last_next     = !fin_over;
                        scan_idx_next   = '0;
                        best_found_next = 1'b0;
                    end
                end
            end
            bblru_pkg::S_REBUILD: begin
                if (out_free) begin
                    op            = bblru_pkg::OP_ALLOC;
                    op_idx        = slot_reg;
                    m_valid_next  = 1'b1;
                    m_status_next = bblru_pkg::ST_MISS;
                    m_slot_next   = SLOT_CAST(slot_reg);
                    m_key_next    = key_reg;
                    m_height_next = height_reg;
                    m_last_next   = 1'b1;
                end
            end
            bblru_pkg::S_SCAN: begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_take) begin
                    best_found_next = 1'b1;
                    best_idx_next   = scan_idx_reg;
                    best_stamp_next = cell_stamp[scan_idx_reg];
                end
            end
            bblru_pkg::S_EVICT: begin
                if (out_free) begin
                    op              = bblru_pkg::OP_FREE;
                    op_idx          = best_idx_reg;
                    retained_next   = retained_evict;
                    m_valid_next    = 1'b1;
                    m_status_next   = bblru_pkg::ST_EVICTED;
                    m_slot_next     = SLOT_CAST(best_idx_reg);
                    m_key_next      = cell_key[best_idx_reg];
                    m_height_next   = cell_height[best_idx_reg];
                    m_last_next     = !evict_over;
                    scan_idx_next   = '0;
                    best_found_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bblru_pkg::S_IDLE;
            budget_reg   <= bblru_pkg::BUDGET_RESET;
            counter_reg  <= '0;
            retained_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            counter_reg  <= counter_next;
            retained_reg <= retained_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) budget_reg <= cfg_byte_budget;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= s_cmd;
            key_reg    <= s_key_digest;
            height_reg <= s_pixel_height;
            force_reg  <= s_force_rebuild;
            bytes_reg  <= s_item_bytes;
        end
        slot_reg       <= slot_next;
        scan_idx_reg   <= scan_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_key_reg      <= m_key_next;
        m_height_reg   <= m_height_next;
        m_last_reg     <= m_last_next;
    end

    assign cfg_ready          = 1'b1;
    assign s_ready            = (state_reg == bblru_pkg::S_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_slot             = m_slot_reg;
    assign m_out_key_digest   = m_key_reg;
    assign m_out_pixel_height = m_height_reg;
    assign m_last             = m_last_reg;

endmodule
`default_nettype wire

// File: rtl/bblru_checker.sv
`default_nettype none
module bblru_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [bblru_pkg::SIZE_W-1:0]      cfg_byte_budget,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic [bblru_pkg::CMD_W-1:0]       s_cmd,
    input wire logic [bblru_pkg::KEY_W-1:0]       s_key_digest,
    input wire logic [bblru_pkg::HEIGHT_W-1:0]    s_pixel_height,
    input wire logic                              s_force_rebuild,
    input wire logic [bblru_pkg::SIZE_W-1:0]      s_item_bytes,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [bblru_pkg::STATUS_W-1:0]    m_status,
    input wire logic [bblru_pkg::SLOT_W-1:0]      m_slot,
    input wire logic [bblru_pkg::KEY_W-1:0]       m_out_key_digest,
    input wire logic [bblru_pkg::HEIGHT_W-1:0]    m_out_pixel_height,
    input wire logic                              m_last
);

    // one item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot)
        && $stable(m_last) && $stable(m_out_key_digest))
        else $error("stalled result changed");

    // single-result outcomes always close the item
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == bblru_pkg::ST_HIT || m_status == bblru_pkg::ST_MISS
        || m_status == bblru_pkg::ST_BUSY || m_status == bblru_pkg::ST_FULL
        || m_status == bblru_pkg::ST_NOT_PENDING) |-> m_last)
        else $error("single result without last");

    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == bblru_pkg::ST_FULL |-> m_slot == '0)
        else $error("table full result with nonzero slot");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown after reset");

endmodule

bind byte_budget_lru_cache_top bblru_checker u_bblru_checker (.*);
`default_nettype wire
